@@ design/kpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// kpdc_pkg
// Shared types and constants of the key press duration classifier.
// ----------------------------------------------------------------------------
package kpdc_pkg;

   localparam int CFG_WIDTH = 16;
   localparam int IDX_WIDTH = 3;

   typedef enum logic [IDX_WIDTH-1:0] {
      REG_CLICK_MIN    = 3'd0,
      REG_CLICK_MAX    = 3'd1,
      REG_HOLD         = 3'd2,
      REG_BOOT_IGNORE  = 3'd3,
      REG_PRESS_LEVEL  = 3'd4
   } reg_index_type;

   localparam logic [CFG_WIDTH-1:0] CLICK_MIN_RESET   = 16'd30;
   localparam logic [CFG_WIDTH-1:0] CLICK_MAX_RESET   = 16'd800;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET        = 16'd1500;
   localparam logic [CFG_WIDTH-1:0] BOOT_IGNORE_RESET = 16'd800;
   localparam logic                 PRESS_LEVEL_RESET = 1'b0;

   localparam logic [3:0] PROGRESS_NONE  = 4'd0;
   localparam logic [3:0] PROGRESS_THIRD = 4'd3;
   localparam logic [3:0] PROGRESS_TWO   = 4'd6;
   localparam logic [3:0] PROGRESS_FULL  = 4'd9;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] click_min;
      logic [CFG_WIDTH-1:0] click_max;
      logic [CFG_WIDTH-1:0] hold;
      logic [CFG_WIDTH-1:0] boot_ignore;
      logic                 press_level;
   } csr_type;

   typedef struct packed {
      logic capture;
      logic diff;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_action;
      logic ignore;
      logic out_free;
   } sts_type;

endpackage

@@ design/kpdc_csr.sv @@
// ----------------------------------------------------------------------------
// kpdc_csr
// Configuration register bank with write-only access.
// ----------------------------------------------------------------------------
module kpdc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [kpdc_pkg::IDX_WIDTH-1:0]  csr_index,
   input  logic [kpdc_pkg::CFG_WIDTH-1:0]  csr_wdata,
   output kpdc_pkg::csr_type               csr
);
   import kpdc_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_CLICK_MIN:    csr_in.click_min    = csr_wdata;
            REG_CLICK_MAX:    csr_in.click_max    = csr_wdata;
            REG_HOLD:         csr_in.hold         = csr_wdata;
            REG_BOOT_IGNORE:  csr_in.boot_ignore  = csr_wdata;
            REG_PRESS_LEVEL:  csr_in.press_level  = csr_wdata[0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.click_min    <= CLICK_MIN_RESET;
         csr_ff.click_max    <= CLICK_MAX_RESET;
         csr_ff.hold         <= HOLD_RESET;
         csr_ff.boot_ignore  <= BOOT_IGNORE_RESET;
         csr_ff.press_level  <= PRESS_LEVEL_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

@@ design/kpdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// kpdc_ctrl
// Sequencer: capture a transaction, form time differences, classify.
// ----------------------------------------------------------------------------
module kpdc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  kpdc_pkg::sts_type sts,
   output kpdc_pkg::cmd_type cmd
);
   import kpdc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIFF = 3'b010,
      S_EVAL = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.diff    = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = sts.is_action ? S_IDLE : S_EVAL;
         end
         S_EVAL: begin
            if (sts.ignore) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/kpdc_dp.sv @@
// ----------------------------------------------------------------------------
// kpdc_dp
// Datapath: timestamps, press timing, classification and result register.
// ----------------------------------------------------------------------------
module kpdc_dp #(
   parameter int TIME_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  kpdc_pkg::cmd_type cmd,
   output kpdc_pkg::sts_type sts,
   input  kpdc_pkg::csr_type csr,
   input  logic              req_action,
   input  logic [31:0]       req_now,
   input  logic              req_pin,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata
);
   import kpdc_pkg::*;

   logic [63:0]           now_wide;
   logic [TIME_WIDTH-1:0] now_t;

   logic                  action_ff,  action_in;
   logic                  pressed_ff, pressed_in;
   logic [TIME_WIDTH-1:0] now_ff,     now_in;
   logic [TIME_WIDTH-1:0] ready_ff,   ready_in;
   logic [TIME_WIDTH-1:0] start_ff,   start_in;
   logic                  timing_ff,  timing_in;
   logic                  ignore_ff,  ignore_in;
   logic [TIME_WIDTH-1:0] held_ff,    held_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff,  rsp_data_in;

   logic                  held_ge_hold;
   logic                  gt_min;
   logic                  lt_max;
   logic [17:0]           held_x3;
   logic [17:0]           hold_x1;
   logic [17:0]           hold_x2;
   logic [3:0]            group_code;
   logic                  res_valid;
   logic [3:0]            res_progress;
   logic                  res_long;
   logic                  res_short;
   logic                  res_release;

   assign now_wide = {32'd0, req_now};
   assign now_t    = now_wide[TIME_WIDTH-1:0];

   assign held_ge_hold = held_ff >= TIME_WIDTH'(csr.hold);
   assign gt_min       = held_ff >  TIME_WIDTH'(csr.click_min);
   assign lt_max       = held_ff <  TIME_WIDTH'(csr.click_max);
   assign held_x3      = {2'b00, held_ff[15:0]} + {1'b0, held_ff[15:0], 1'b0};
   assign hold_x1      = {2'b00, csr.hold};
   assign hold_x2      = {1'b0, csr.hold, 1'b0};

   always_comb begin
      if (held_x3 >= hold_x2) begin
         group_code = PROGRESS_TWO;
      end else if (held_x3 >= hold_x1) begin
         group_code = PROGRESS_THIRD;
      end else begin
         group_code = PROGRESS_NONE;
      end
   end

   always_comb begin
      res_valid    = 1'b0;
      res_progress = PROGRESS_NONE;
      res_long     = 1'b0;
      res_short    = 1'b0;
      res_release  = 1'b0;
      if (pressed_ff) begin
         res_valid    = 1'b1;
         res_progress = held_ge_hold ? PROGRESS_FULL : group_code;
         res_long     = held_ge_hold;
      end else if (timing_ff) begin
         res_short   = gt_min && lt_max;
         res_release = !lt_max;
      end
   end

   always_comb begin
      action_in    = action_ff;
      pressed_in   = pressed_ff;
      now_in       = now_ff;
      ready_in     = ready_ff;
      start_in     = start_ff;
      timing_in    = timing_ff;
      ignore_in    = ignore_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.capture) begin
         action_in  = req_action;
         pressed_in = (req_pin == csr.press_level);
         now_in     = now_t;
      end
      if (cmd.diff) begin
         ignore_in = (now_ff - ready_ff) < TIME_WIDTH'(csr.boot_ignore);
         held_in   = timing_ff ? (now_ff - start_ff) : '0;
         if (action_ff) begin
            ready_in = now_ff;
         end
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_release, res_short, res_long, res_progress, res_valid};
         timing_in    = pressed_ff && !held_ge_hold;
         if (pressed_ff && !timing_ff) begin
            start_in = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         start_ff     <= '0;
         timing_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         start_ff     <= start_in;
         timing_ff    <= timing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      pressed_ff  <= pressed_in;
      now_ff      <= now_in;
      ignore_ff   <= ignore_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.is_action = action_ff;
   assign sts.ignore    = ignore_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/key_press_duration_classifier.sv @@
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// Classifies key presses from timestamped scan ticks: hold progress, long
// press, short press and release events, with a boot ignore window.
// A new transaction is taken only when the previous one is done, by the
// three-state sequencer (capture, difference, classify); its result is
// registered in classify, and an enable action ends after difference.
// A stalled result holds classify.
// Reset: synchronous; registers return to defaults, ready time and timing clear.
// ----------------------------------------------------------------------------
module key_press_duration_classifier #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] now_ms, [32] pin_level, [39:33] zero
   input  logic [39:0]                     req_tdata,
   // [0] action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] progress_valid, [4:1] progress, [5] long_press, [6] short_press,
   // [7] release_event
   output logic [7:0]                      rsp_tdata,
   input  logic                            csr_wen,
   input  logic [kpdc_pkg::IDX_WIDTH-1:0]  csr_index,
   input  logic [kpdc_pkg::CFG_WIDTH-1:0]  csr_wdata
);
   import kpdc_pkg::*;

   csr_type csr;
   cmd_type cmd;
   sts_type sts;

   kpdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   kpdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kpdc_dp #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr        (csr),
      .req_action (req_tuser),
      .req_now    (req_tdata[31:0]),
      .req_pin    (req_tdata[32]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
